/* rtl/bsrp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrp_pkg
// Shared types and constants of the bus shadow register probe block.
// ----------------------------------------------------------------------------
package bsrp_pkg;

  // Payload widths
  localparam int ADDR_W    = 13;
  localparam int REG_W     = 12;   // address after the upper alias is folded down
  localparam int SIZE_W    = 4;
  localparam int DATA_W    = 64;
  localparam int WORD_W    = 32;
  localparam int BUF_BYTES = 12;   // an access spans at most three dwords
  localparam int S_TDATA_W = 88;   // 13 + 4 + 64 = 81 bits, padded to whole bytes
  localparam int M_TDATA_W = 64;

  // Address map
  localparam int unsigned WIN_BASE = 32'h0000_0200;
  localparam int unsigned REG_DATA = 32'h0000_021C;
  localparam int unsigned REG_CTLA = 32'h0000_0220;
  localparam int unsigned REG_CTLB = 32'h0000_0228;

  // Generator coefficients
  localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SHADOW_RD,
    OP_SHADOW_WR,
    OP_CTL_RD,
    OP_DATA_RD
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_issue;
    logic       wr_issue;
    logic [1:0] k;
    logic       mul;
    logic       gen;
    logic       store;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e        in_op;
    op_e        op;
    logic [1:0] nwords_m1;
  } stat_t;

endpackage : bsrp_pkg
`default_nettype wire

/* rtl/bsrp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : bsrp_ram
`default_nettype wire

/* rtl/bsrp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrp_ctrl
// Sequencer: steps one access through the shadow reads, write-back or
// generator update it needs, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bsrp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  input  wire bsrp_pkg::stat_t stat_i,
  output bsrp_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SETTLE,
    S_WRITE,
    S_MUL,
    S_GEN,
    S_STORE,
    S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       m_valid_q, m_valid_d;

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    m_valid_d = m_valid_q;
    cmd_o     = '0;
    cmd_o.k   = k_q;

    if (m_valid_q && m_ready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          k_d        = 2'd0;
          case (stat_i.in_op)
            bsrp_pkg::OP_SHADOW_RD,
            bsrp_pkg::OP_SHADOW_WR: state_d = S_READ;
            bsrp_pkg::OP_DATA_RD:   state_d = S_MUL;
            default:                state_d = S_DONE;
          endcase
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (k_q == stat_i.nwords_m1) begin
          state_d = S_SETTLE;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_SETTLE: begin
        k_d = 2'd0;
        if (stat_i.op == bsrp_pkg::OP_SHADOW_WR) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_issue = 1'b1;
        if (k_q == stat_i.nwords_m1) begin
          state_d = S_DONE;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_GEN;
      end
      S_GEN: begin
        cmd_o.gen = 1'b1;
        state_d   = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free or being drained
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= 2'd0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

endmodule : bsrp_ctrl
`default_nettype wire

/* rtl/bsrp_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrp_dp
// Datapath: access decode, shadow RAM with per-word valid bits, byte merge
// buffer, probe generator, control words and the result register.
// ----------------------------------------------------------------------------
module bsrp_dp #(
  parameter int SHADOW_WORDS     = 64,
  parameter int MAX_ACCESS_BYTES = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bsrp_pkg::cmd_t                   cmd_i,
  output bsrp_pkg::stat_t                       stat_o,
  input  wire logic [bsrp_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  wire logic                             s_tuser_i,
  output logic      [bsrp_pkg::M_TDATA_W-1:0]   m_tdata_o,
  output logic                                  m_tuser_o
);

  localparam int IW = $clog2(SHADOW_WORDS);
  localparam int BUF_W = 8 * bsrp_pkg::BUF_BYTES;
  localparam int WIN_END_I = int'(bsrp_pkg::WIN_BASE) + 4 * SHADOW_WORDS;
  localparam logic [12:0] WinEnd   = 13'(WIN_END_I);
  localparam logic [12:0] WinBase  = 13'(bsrp_pkg::WIN_BASE);
  localparam logic [11:0] RegData  = 12'(bsrp_pkg::REG_DATA);
  localparam logic [11:0] RegCtla  = 12'(bsrp_pkg::REG_CTLA);
  localparam logic [11:0] RegCtlb  = 12'(bsrp_pkg::REG_CTLB);
  localparam logic [3:0]  MaxSize  = 4'(MAX_ACCESS_BYTES);
  localparam logic [10:0] WordBase = 11'(bsrp_pkg::WIN_BASE / 4);
  localparam logic [10:0] Words    = 11'(SHADOW_WORDS);
  localparam logic [10:0] DataWord = 11'((bsrp_pkg::REG_DATA - bsrp_pkg::WIN_BASE) / 4);
  localparam bit          DataInWin = int'(bsrp_pkg::REG_DATA) < WIN_END_I;

  // ---------------- incoming decode
  logic [11:0]  in_reg;
  logic [3:0]   in_size_raw, in_size, in_span;
  logic         in_win, in_ctl;
  bsrp_pkg::op_e in_op;

  assign in_reg      = s_tdata_i[11:0];   // 0x1000..0x1FFF fold onto 0x000..0xFFF
  assign in_size_raw = s_tdata_i[16:13];
  assign in_size     = (in_size_raw > MaxSize) ? MaxSize : in_size_raw;
  assign in_span     = {2'b00, in_reg[1:0]} + in_size - 4'd1;
  assign in_win      = ({1'b0, in_reg} >= WinBase) && ({1'b0, in_reg} < WinEnd);
  assign in_ctl      = (in_reg == RegCtla) || (in_reg == RegCtlb);

  always_comb begin
    in_op = bsrp_pkg::OP_NONE;
    if (!s_tuser_i) begin
      if (in_reg == RegData)  in_op = bsrp_pkg::OP_DATA_RD;
      else if (in_ctl)        in_op = bsrp_pkg::OP_CTL_RD;
      else if (in_win)        in_op = bsrp_pkg::OP_SHADOW_RD;
    end else if (in_ctl || in_win) begin
      in_op = bsrp_pkg::OP_SHADOW_WR;
    end
  end

  // ---------------- request registers (payload, no reset)
  bsrp_pkg::op_e op_q;
  logic [11:0]   reg_q;
  logic [3:0]    size_q;
  logic [63:0]   wdata_q;
  logic [1:0]    nw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_op;
      reg_q   <= in_reg;
      size_q  <= in_size;
      wdata_q <= s_tdata_i[80:17];
      nw_q    <= (in_size == 4'd0) ? 2'd0 : in_span[3:2];
    end
  end

  assign stat_o.in_op     = in_op;
  assign stat_o.op        = op_q;
  assign stat_o.nwords_m1 = nw_q;

  // ---------------- word addressing and byte lanes
  logic [1:0]         off;
  logic [10:0]        widx;
  logic               w_in_rng;
  logic [12:0]        wb_addr;
  logic [11:0]        bmask, rmask;
  logic [BUF_W-1:0]   buf_q, wsh, merged, rsh;
  logic [63:0]        rd_bytes;
  logic               win_q;
  logic               shadow_op, range_err;

  assign off      = reg_q[1:0];
  assign widx     = {1'b0, reg_q[11:2]} - WordBase + {9'd0, cmd_i.k};
  assign w_in_rng = widx < Words;
  assign wb_addr  = {1'b0, reg_q[11:2], 2'b00};
  assign win_q    = ({1'b0, reg_q} >= WinBase) && ({1'b0, reg_q} < WinEnd);

  always_comb begin
    for (int j = 0; j < bsrp_pkg::BUF_BYTES; j++) begin
      bmask[j] = (4'(j) >= {2'b00, off}) && (4'(j) < ({2'b00, off} + size_q)) &&
                 ((wb_addr + 13'(j)) < WinEnd);
    end
  end

  assign wsh = BUF_W'(wdata_q) << {off, 3'b000};
  assign rsh = buf_q >> {off, 3'b000};
  assign rmask = bmask >> off;

  always_comb begin
    for (int j = 0; j < bsrp_pkg::BUF_BYTES; j++) begin
      merged[8*j +: 8] = bmask[j] ? wsh[8*j +: 8] : buf_q[8*j +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      rd_bytes[8*i +: 8] = rmask[i] ? rsh[8*i +: 8] : 8'h00;
    end
  end

  assign shadow_op = (op_q == bsrp_pkg::OP_SHADOW_RD) || (op_q == bsrp_pkg::OP_SHADOW_WR);
  assign range_err = shadow_op && (size_q != 4'd0) &&
                     (({1'b0, reg_q} + 13'(size_q)) > WinEnd);

  // ---------------- generator and control words (state, reset)
  logic [31:0] gen_q, prod_q, ctla_q, ctlb_q, probe_r;
  logic [31:0] ctl_old, ctl_merge, ctl_new;
  logic [SHADOW_WORDS-1:0] valid_q;
  logic        vld_rd_q, cap_en_q;
  logic [1:0]  cap_k_q;

  assign probe_r = gen_q ^ {ctlb_q[24:0], 7'b0};
  assign ctl_old = (reg_q == RegCtla) ? ctla_q : ctlb_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ctl_merge[8*i +: 8] = (4'(i) < size_q) ? wdata_q[8*i +: 8] : ctl_old[8*i +: 8];
    end
  end

  assign ctl_new = win_q ? merged[31:0] : ctl_merge;

  // ---------------- shadow RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  assign ram_raddr = widx[IW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx[IW-1:0];
    ram_wdata = merged[32*cmd_i.k +: 32];
    if (cmd_i.wr_issue) begin
      ram_we = w_in_rng;
    end else if (cmd_i.store) begin
      ram_we    = DataInWin;
      ram_waddr = DataWord[IW-1:0];
      ram_wdata = probe_r;
    end
  end

  bsrp_ram #(
    .WIDTH (32),
    .DEPTH (SHADOW_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q    <= '0;
      ctla_q   <= '0;
      ctlb_q   <= '0;
      valid_q  <= '0;
      cap_en_q <= 1'b0;
    end else begin
      cap_en_q <= cmd_i.rd_issue;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (cmd_i.gen) begin
        gen_q <= prod_q + bsrp_pkg::LCG_ADD + (ctla_q ^ ctlb_q);
      end
      // latch the control word as the result is loaded into the output register
      if (cmd_i.out_load && (op_q == bsrp_pkg::OP_SHADOW_WR)) begin
        if (reg_q == RegCtla) ctla_q <= ctl_new;
        if (reg_q == RegCtlb) ctlb_q <= ctl_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 32'(gen_q * bsrp_pkg::LCG_MUL);
    end
    if (cmd_i.rd_issue) begin
      vld_rd_q <= w_in_rng && valid_q[ram_raddr];
      cap_k_q  <= cmd_i.k;
    end
    if (cap_en_q) begin
      buf_q[32*cap_k_q +: 32] <= vld_rd_q ? ram_rdata : 32'h0;
    end
    if (cmd_i.out_load) begin
      m_tuser_o <= range_err;
      case (op_q)
        bsrp_pkg::OP_SHADOW_RD: m_tdata_o <= rd_bytes;
        bsrp_pkg::OP_CTL_RD:    m_tdata_o <= {32'h0, ctl_old};
        bsrp_pkg::OP_DATA_RD:   m_tdata_o <= {32'h0, probe_r};
        default:                m_tdata_o <= '0;
      endcase
    end
  end

endmodule : bsrp_dp
`default_nettype wire

/* rtl/bus_shadow_register_probe_block.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bus_shadow_register_probe_block
// Register block with a byte-addressed shadow window of little-endian dwords,
// a probe data register backed by a linear congruential generator and two
// probe control registers.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                     Contents
//  s_axis   in   s_axis_tvalid/s_axis_tready   one access: kind, address, size, data
//  m_axis   out  m_axis_tvalid/m_axis_tready   one result: read data, range error
//
//  Sequence: a shadow read fetches its n dwords (1 to 3), a shadow write fetches
//  and writes them back with the new bytes merged, and a probe data read passes
//  the registered generator multiplier, generator update and store; any other
//  access goes straight to its result. s_axis_tready returns as m_axis_tvalid
//  rises. The sequencer steps the shadow RAM one dword read or written per cycle.
//  Reset: rst_ni clears the controller, generator, control words and the
//  per-dword valid bits, so the whole window reads zero at once; no clearing
//  pass runs.
//  Stalls: a result waiting on m_axis_tready does not block the next
//  access, which proceeds until its own result needs the output register.
//
module bus_shadow_register_probe_block #(
  parameter int SHADOW_WORDS     = 64,   // dwords in the shadow window, 4..256
  parameter int MAX_ACCESS_BYTES = 8     // access sizes above this saturate, 1..8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // access transactions
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [12:0] address, [16:13] access_size, [80:17] write_data, [87:81] zero
  input  wire logic [bsrp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] req_type (0 read, 1 write)
  input  wire logic                           s_axis_tuser,
  // result transactions
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [63:0] read_data
  output logic      [bsrp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] range_error
  output logic                                m_axis_tuser
);

  bsrp_pkg::cmd_t  cmd;
  bsrp_pkg::stat_t stat;

  // Sequencer: one access at a time through read, write-back or generator steps
  bsrp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Datapath: decode, shadow RAM, byte merge, generator and result register
  bsrp_dp #(
    .SHADOW_WORDS     (SHADOW_WORDS),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser)
  );

endmodule : bus_shadow_register_probe_block
`default_nettype wire

/* rtl/bsrp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrp_checker
// Port-level checks of the bus shadow register probe block.
// ----------------------------------------------------------------------------
module bsrp_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [bsrp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [bsrp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tuser
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one access in flight: ready drops after every accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("access accepted while another is in flight");

  // no result in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // a new result coincides with the block returning to accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while the sequencer is busy");

endmodule : bsrp_checker

bind bus_shadow_register_probe_block bsrp_checker u_bsrp_checker (.*);
`default_nettype wire
